// ----- hdl/ufc_pkg.sv -----
// Package with status codes, register addresses and the CRC-32 byte update for the frame checker.
package ufc_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_FLAG = 3'd1,
        ST_LEN  = 3'd2,
        ST_CMD  = 3'd3,
        ST_CRC  = 3'd4
    } status_t;

    // Register index, taken from the word address on the configuration port.
    typedef enum logic {
        REG_FRAME_FLAG  = 1'b0,
        REG_MAX_COMMAND = 1'b1
    } reg_idx_t;

    localparam int unsigned TAIL_DEPTH     = 5;
    localparam int unsigned COUNT_W        = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] FRAME_OVERHEAD = 17'd10;
    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET     = 32'hFFFF_FFFF;
    localparam logic [15:0] WORD_NOT_OK    = 16'hFFFF;
    localparam logic [7:0]  FLAG_RESET     = 8'h00;
    localparam logic [7:0]  MAX_CMD_RESET  = 8'hFF;

    // One byte of the reflected CRC-32, shifted in least significant bit first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0] data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

// ----- hdl/ufc_in_if.sv -----
// Input channel of the frame checker: one received byte and its last-byte mark.
interface ufc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_last;

    modport source (output valid, output rx_byte, output frame_last, input ready);
    modport sink (input valid, input rx_byte, input frame_last, output ready);
endinterface

// ----- hdl/ufc_out_if.sv -----
// Output channel of the frame checker: frame status and error/command word.
interface ufc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] cmd_word;

    modport source (output valid, output status, output cmd_word, input ready);
    modport sink (input valid, input status, input cmd_word, output ready);
endinterface

// ----- hdl/upgrade_frame_checker.sv -----
// Frame checker: flag, length, command and CRC-32 checks on a byte stream.
// The result of a frame appears in the cycle after its last byte is accepted.
// Throughput: one byte per cycle unless stalled; CRC updated from the sixth byte on.
// A new byte is taken while the output register is empty or is being emptied.
// Reset (rst_n, asynchronous, active low) clears the frame state and the output
// valid flag, and sets frame_flag to 0 and max_command to 255.
module upgrade_frame_checker (
    input  logic              clk,
    input  logic              rst_n,
    ufc_in_if.sink            in_ch,
    ufc_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ufc_pkg::*;

    // Configuration registers.
    logic [7:0] frame_flag_reg;
    logic [7:0] max_command_reg;

    // Frame state.
    logic [7:0]         tail_reg [TAIL_DEPTH];
    logic [COUNT_W-1:0] byte_count_reg;
    logic [31:0]        crc_reg;
    logic               first_ok_reg;
    logic [15:0]        header_reg;
    logic [15:0]        length_reg;

    // Output register.
    logic        out_valid_reg;
    status_t     status_reg;
    logic [15:0] word_reg;

    logic               in_fire;
    logic               cfg_write;
    reg_idx_t           reg_idx;
    logic               first_ok_next;
    logic [15:0]        header_next;
    logic [15:0]        length_next;
    logic [31:0]        crc_next;
    logic [COUNT_W-1:0] count_next;
    logic [31:0]        rx_crc;
    status_t            status_next;
    logic [15:0]        word_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = reg_idx_t'(paddr[2]);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_flag_reg  <= FLAG_RESET;
            max_command_reg <= MAX_CMD_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_FRAME_FLAG:  frame_flag_reg  <= pwdata[7:0];
                REG_MAX_COMMAND: max_command_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Configuration read data.
    always_comb
    begin
        case (reg_idx)
            REG_FRAME_FLAG:  prdata = {24'd0, frame_flag_reg};
            REG_MAX_COMMAND: prdata = {24'd0, max_command_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // A byte is taken whenever the output register can hold a new result.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Header capture by byte position, CRC over the byte leaving the delay line.
    always_comb
    begin
        first_ok_next = first_ok_reg;
        header_next   = header_reg;
        length_next   = length_reg;
        case (byte_count_reg)
            17'd0: first_ok_next      = (in_ch.rx_byte == frame_flag_reg);
            17'd1: header_next[15:8]  = in_ch.rx_byte;
            17'd2: header_next[7:0]   = in_ch.rx_byte;
            17'd3: length_next[15:8]  = in_ch.rx_byte;
            17'd4: length_next[7:0]   = in_ch.rx_byte;
            default: ;
        endcase

        if (byte_count_reg >= COUNT_W'(TAIL_DEPTH))
            crc_next = crc32_byte(crc_reg, tail_reg[0]);
        else
            crc_next = crc_reg;

        if (byte_count_reg != COUNT_MAX)
            count_next = byte_count_reg + 1'b1;
        else
            count_next = byte_count_reg;

        // The four newest bytes of the delay line hold the received CRC.
        rx_crc = {tail_reg[1], tail_reg[2], tail_reg[3], tail_reg[4]};
    end

    // Checks in priority order on the final byte.
    always_comb
    begin
        word_next = WORD_NOT_OK;
        if (!first_ok_next || (in_ch.rx_byte != frame_flag_reg))
            status_next = ST_FLAG;
        else if (({1'b0, length_next} + FRAME_OVERHEAD) != count_next)
            status_next = ST_LEN;
        else if (header_next[7:0] > max_command_reg)
            status_next = ST_CMD;
        else if (rx_crc != (crc_next ^ CRC_PRESET))
            status_next = ST_CRC;
        else
        begin
            status_next = ST_OK;
            word_next   = header_next;
        end
    end

    // Frame state update; the last byte returns it to the start of a frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAIL_DEPTH; i++)
                tail_reg[i] <= 8'd0;
            byte_count_reg <= '0;
            crc_reg        <= CRC_PRESET;
            first_ok_reg   <= 1'b0;
            header_reg     <= 16'd0;
            length_reg     <= 16'd0;
        end
        else if (in_fire)
        begin
            if (in_ch.frame_last)
            begin
                for (int i = 0; i < TAIL_DEPTH; i++)
                    tail_reg[i] <= 8'd0;
                byte_count_reg <= '0;
                crc_reg        <= CRC_PRESET;
                first_ok_reg   <= 1'b0;
                header_reg     <= 16'd0;
                length_reg     <= 16'd0;
            end
            else
            begin
                for (int i = 0; i < TAIL_DEPTH - 1; i++)
                    tail_reg[i] <= tail_reg[i+1];
                tail_reg[TAIL_DEPTH-1] <= in_ch.rx_byte;
                byte_count_reg <= count_next;
                crc_reg        <= crc_next;
                first_ok_reg   <= first_ok_next;
                header_reg     <= header_next;
                length_reg     <= length_next;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && in_ch.frame_last)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.frame_last)
        begin
            status_reg <= status_next;
            word_reg   <= word_next;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.status   = status_reg;
    assign out_ch.cmd_word = word_reg;

`ifndef ASSERT_OFF
    // A final byte always leaves a result in the output register.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_ch.frame_last) |=> out_valid_reg)
        else $error("final byte did not produce a result");

    // A final byte returns the frame state to the start of a frame.
    a_last_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_ch.frame_last) |=>
            (byte_count_reg == '0) && (crc_reg == CRC_PRESET) && !first_ok_reg)
        else $error("frame state not cleared after final byte");

    // A failed frame reports the all-ones word.
    a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |-> (word_reg == WORD_NOT_OK))
        else $error("failed frame with a command word other than all ones");

    // A byte that is not final produces no new result.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !in_ch.frame_last && out_ch.ready) |=> !out_valid_reg)
        else $error("result produced without a final byte");
`endif

endmodule
